FILE: hw/rtl/trms_pkg.sv
package trms_pkg;

   localparam int DATA_W    = 32;
   localparam int REG_COUNT = 4;
   localparam int REG_IDX_W = $clog2(REG_COUNT);
   localparam int PC_W      = 3;
   localparam int PROG_LEN  = 4;
   localparam int MDU_CNT_W = $clog2(DATA_W);

   localparam logic MODE_LOAD = 1'b0;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_MOD = 4'd4,
      OP_INC = 4'd5,
      OP_DEC = 4'd6,
      OP_MOV = 4'd7,
      OP_NOT = 4'd8,
      OP_GT  = 4'd9,
      OP_LT  = 4'd10,
      OP_EQ  = 4'd11,
      OP_JMP = 4'd12,
      OP_JZ  = 4'd13,
      OP_JNZ = 4'd14,
      OP_NOP = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      MDU_MUL,
      MDU_DIV,
      MDU_MOD
   } mdu_kind_type;

   typedef struct packed {
      logic         start;
      mdu_kind_type kind;
   } mdu_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mdu_status_type;

   typedef logic [REG_COUNT-1:0][DATA_W-1:0] regs_type;

   typedef struct packed {
      logic                     mode;
      logic [7:0]               instruction;
      logic [1:0]               current_pc;
      logic [1:0]               reg_index;
      logic signed [DATA_W-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic [PC_W-1:0]          next_pc;
      logic signed [DATA_W-1:0] reg_a;
      logic signed [DATA_W-1:0] reg_b;
      logic signed [DATA_W-1:0] reg_c;
      logic signed [DATA_W-1:0] reg_d;
   } rsp_type;

   // Jump targets treat the register as unsigned, so the pc is never negative.
   function automatic logic [PC_W-1:0] jump_target(input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] rem;
      rem = value % DATA_W'(PROG_LEN);
      return rem[PC_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/trms_regfile.sv
module trms_regfile (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [trms_pkg::REG_IDX_W-1:0]   wr_idx,
   input  logic [trms_pkg::DATA_W-1:0]      wr_data,
   input  logic [trms_pkg::REG_IDX_W-1:0]   rd_idx,
   output logic [trms_pkg::DATA_W-1:0]      rd_data,
   output trms_pkg::regs_type               regs
);
   import trms_pkg::*;

   regs_type regs_ff;
   regs_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         regs_in[wr_idx] = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign rd_data = regs_ff[rd_idx];
   assign regs    = regs_ff;

endmodule

FILE: hw/rtl/trms_mdu.sv
module trms_mdu (
   input  logic                         clock,
   input  logic                         reset,
   input  trms_pkg::mdu_ctrl_type       ctrl,
   input  logic [trms_pkg::DATA_W-1:0]  operand_a,
   input  logic [trms_pkg::DATA_W-1:0]  operand_b,
   output trms_pkg::mdu_status_type     status,
   output logic [trms_pkg::DATA_W-1:0]  result
);
   import trms_pkg::*;

   typedef enum logic [1:0] {
      M_IDLE,
      M_STEP,
      M_FIX
   } mdu_state_type;

   mdu_state_type         state_ff, state_in;
   mdu_kind_type          kind_ff, kind_in;
   logic [MDU_CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0]     acc_ff, acc_in;
   logic [DATA_W-1:0]     x_ff, x_in;
   logic [DATA_W-1:0]     y_ff, y_in;
   logic                  neg_q_ff, neg_q_in;
   logic                  neg_r_ff, neg_r_in;
   logic [DATA_W-1:0]     result_ff, result_in;
   logic                  done_ff, done_in;

   // The one adder that every iteration and the final sign fix share.
   logic [DATA_W-1:0]     add_x;
   logic [DATA_W-1:0]     add_y;
   logic                  add_sub;
   logic [DATA_W:0]       sum;
   logic [DATA_W-1:0]     mag_a;
   logic [DATA_W-1:0]     mag_b;

   assign sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (DATA_W+1)'(add_sub);

   assign mag_a = operand_a[DATA_W-1] ? (DATA_W'(0) - operand_a) : operand_a;
   assign mag_b = operand_b[DATA_W-1] ? (DATA_W'(0) - operand_b) : operand_b;

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      neg_q_in  = neg_q_ff;
      neg_r_in  = neg_r_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      add_x     = '0;
      add_y     = '0;
      add_sub   = 1'b0;
      unique case (state_ff)
         M_IDLE: begin
            if (ctrl.start) begin
               kind_in  = ctrl.kind;
               count_in = '0;
               acc_in   = '0;
               neg_q_in = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
               neg_r_in = operand_a[DATA_W-1];
               if (ctrl.kind == MDU_MUL) begin
                  x_in = operand_a;
                  y_in = operand_b;
               end else begin
                  x_in = mag_a;
                  y_in = mag_b;
               end
               state_in = M_STEP;
            end
         end
         M_STEP: begin
            if (kind_ff == MDU_MUL) begin
               add_x = acc_ff;
               add_y = x_ff;
               if (y_ff[0]) begin
                  acc_in = sum[DATA_W-1:0];
               end
               x_in = {x_ff[DATA_W-2:0], 1'b0};
               y_in = {1'b0, y_ff[DATA_W-1:1]};
            end else begin
               // Restoring division: the carry out of the subtract is the quotient bit.
               add_x   = {acc_ff[DATA_W-2:0], x_ff[DATA_W-1]};
               add_y   = y_ff;
               add_sub = 1'b1;
               acc_in  = sum[DATA_W] ? sum[DATA_W-1:0] : add_x;
               x_in    = {x_ff[DATA_W-2:0], sum[DATA_W]};
            end
            count_in = count_ff + MDU_CNT_W'(1);
            if (count_ff == MDU_CNT_W'(DATA_W - 1)) begin
               state_in = M_FIX;
            end
         end
         M_FIX: begin
            unique case (kind_ff)
               MDU_MUL: begin
                  add_x = acc_ff;
               end
               MDU_DIV: begin
                  add_y   = x_ff;
                  add_sub = neg_q_ff;
               end
               MDU_MOD: begin
                  add_y   = acc_ff;
                  add_sub = neg_r_ff;
               end
               default: begin
                  add_x = acc_ff;
               end
            endcase
            result_in = sum[DATA_W-1:0];
            done_in   = 1'b1;
            state_in  = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      kind_ff   <= kind_in;
      count_ff  <= count_in;
      acc_ff    <= acc_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      neg_q_ff  <= neg_q_in;
      neg_r_ff  <= neg_r_in;
      result_ff <= result_in;
   end

   assign status.busy = (state_ff != M_IDLE);
   assign status.done = done_ff;
   assign result      = result_ff;

endmodule

FILE: hw/rtl/tiny_register_machine_step_unit.sv
// Executes one instruction of a four-register, 32-bit toy machine per request
// transaction, or loads one register when mode is zero, and answers each request with
// one response transaction carrying the next pc and all four registers. The block
// handles one request at a time: a load goes straight to its write and response,
// other opcodes first read their operands from the register file one per cycle, and
// mul, div and mod then wait on the multiply/divide unit, which runs on one shared
// adder a setup, 32 shift-and-add or shift-and-subtract steps and a sign fix.
// A new request is taken while the previous response still waits. Div and mod
// by zero leave the destination unchanged; jump targets use the register's value
// modulo the program length of 4.
module tiny_register_machine_step_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  trms_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output trms_pkg::rsp_type rsp_data
);
   import trms_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_A,
      S_READ_B,
      S_EXEC,
      S_WAIT,
      S_WRITE,
      S_OUTPUT
   } state_type;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [REG_IDX_W-1:0]   dst_ff, dst_in;
   logic [REG_IDX_W-1:0]   src_ff, src_in;
   logic [DATA_W-1:0]      a_ff, a_in;
   logic [DATA_W-1:0]      b_ff, b_in;
   logic [DATA_W-1:0]      result_ff, result_in;
   logic                   wen_ff, wen_in;
   logic [PC_W-1:0]        next_pc_ff, next_pc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   mdu_ctrl_type           mdu_ctrl;
   mdu_status_type         mdu_status;
   logic [DATA_W-1:0]      mdu_result;

   logic                   rf_wr_en;
   logic [REG_IDX_W-1:0]   rf_rd_idx;
   logic [DATA_W-1:0]      rf_rd_data;
   regs_type               regs;

   assign rf_wr_en  = (state_ff == S_WRITE) && wen_ff;
   assign rf_rd_idx = (state_ff == S_READ_A) ? dst_ff : src_ff;

   trms_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rf_wr_en),
      .wr_idx  (dst_ff),
      .wr_data (result_ff),
      .rd_idx  (rf_rd_idx),
      .rd_data (rf_rd_data),
      .regs    (regs)
   );

   trms_mdu u_mdu (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mdu_ctrl),
      .operand_a (a_ff),
      .operand_b (b_ff),
      .status    (mdu_status),
      .result    (mdu_result)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      dst_in        = dst_ff;
      src_in        = src_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      result_in     = result_ff;
      wen_in        = wen_ff;
      next_pc_in    = next_pc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      mdu_ctrl      = '{start: 1'b0, kind: MDU_MUL};
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = op_type'(req_data.instruction[7:4]);
               src_in     = req_data.instruction[1:0];
               next_pc_in = {1'b0, req_data.current_pc};
               result_in  = req_data.load_value;
               wen_in     = 1'b1;
               if (req_data.mode == MODE_LOAD) begin
                  dst_in   = req_data.reg_index;
                  state_in = S_WRITE;
               end else begin
                  dst_in   = req_data.instruction[3:2];
                  state_in = S_READ_A;
               end
            end
         end
         S_READ_A: begin
            a_in     = rf_rd_data;
            state_in = S_READ_B;
         end
         S_READ_B: begin
            b_in     = rf_rd_data;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            next_pc_in = next_pc_ff + PC_W'(1);
            wen_in     = 1'b1;
            state_in   = S_WRITE;
            unique case (op_ff)
               OP_ADD: result_in = a_ff + b_ff;
               OP_SUB: result_in = a_ff - b_ff;
               OP_MUL: begin
                  mdu_ctrl = '{start: 1'b1, kind: MDU_MUL};
                  state_in = S_WAIT;
               end
               OP_DIV: begin
                  mdu_ctrl = '{start: 1'b1, kind: MDU_DIV};
                  wen_in   = (b_ff != '0);
                  state_in = S_WAIT;
               end
               OP_MOD: begin
                  mdu_ctrl = '{start: 1'b1, kind: MDU_MOD};
                  wen_in   = (b_ff != '0);
                  state_in = S_WAIT;
               end
               OP_INC: result_in = a_ff + DATA_W'(1);
               OP_DEC: result_in = a_ff - DATA_W'(1);
               OP_MOV: result_in = b_ff;
               OP_NOT: result_in = ~a_ff;
               OP_GT:  result_in = DATA_W'($signed(a_ff) > $signed(b_ff));
               OP_LT:  result_in = DATA_W'($signed(a_ff) < $signed(b_ff));
               OP_EQ:  result_in = DATA_W'(a_ff == b_ff);
               OP_JMP: begin
                  wen_in     = 1'b0;
                  next_pc_in = jump_target(a_ff);
               end
               OP_JZ: begin
                  wen_in = 1'b0;
                  if (a_ff == '0) begin
                     next_pc_in = jump_target(b_ff);
                  end
               end
               OP_JNZ: begin
                  wen_in = 1'b0;
                  if (a_ff != '0) begin
                     next_pc_in = jump_target(b_ff);
                  end
               end
               OP_NOP: wen_in = 1'b0;
               default: wen_in = 1'b0;
            endcase
         end
         S_WAIT: begin
            if (mdu_status.done) begin
               result_in = mdu_result;
               state_in  = S_WRITE;
            end
         end
         S_WRITE: begin
            state_in = S_OUTPUT;
         end
         S_OUTPUT: begin
            // The register file already holds the written value in this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.next_pc = next_pc_ff;
               rsp_data_in.reg_a   = regs[0];
               rsp_data_in.reg_b   = regs[1];
               rsp_data_in.reg_c   = regs[2];
               rsp_data_in.reg_d   = regs[3];
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      dst_ff      <= dst_in;
      src_ff      <= src_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      result_ff   <= result_in;
      wen_ff      <= wen_in;
      next_pc_ff  <= next_pc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_mdu_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mdu_status.done |-> (state_ff == S_WAIT))
      else $error("multiply/divide unit finished outside the wait state");

   a_mdu_start_idle: assert property (@(posedge clock) disable iff (reset)
      mdu_ctrl.start |-> !mdu_status.busy)
      else $error("multiply/divide unit started while busy");

   a_regs_write_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_WRITE) |=> $stable(regs))
      else $error("register file changed outside the write state");

   a_rsp_from_output: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUTPUT))
      else $error("response raised without passing the output state");

endmodule

FILE: tb/tiny_register_machine_step_unit_tb.sv
`timescale 1ns / 1ps

module tiny_register_machine_step_unit_tb;
   import trms_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int RANDOM_ITEMS = 1300;

   // Keeps its own copy of the register file and a queue of machine states that the
   // block owes, one per accepted request transaction.
   class register_machine_scoreboard;
      logic [DATA_W-1:0] reg_file [REG_COUNT];
      rsp_type           predicted_states [$];
      int unsigned       errors;
      int unsigned       responses;
      int unsigned       loads;
      int unsigned       instructions;
      logic [15:0]       opcodes_seen;

      function new();
         foreach (reg_file[i]) reg_file[i] = '0;
         errors       = 0;
         responses    = 0;
         loads        = 0;
         instructions = 0;
         opcodes_seen = '0;
      endfunction

      function logic [DATA_W-1:0] magnitude(logic [DATA_W-1:0] v);
         return v[DATA_W-1] ? (32'd0 - v) : v;
      endfunction

      function rsp_type step_machine(req_type r);
         op_type            op;
         logic [1:0]        rd;
         logic [1:0]        rs;
         logic [DATA_W-1:0] a;
         logic [DATA_W-1:0] b;
         logic [DATA_W-1:0] quotient;
         logic [DATA_W-1:0] remainder;
         logic [PC_W-1:0]   next_pc;
         rsp_type           state;
         next_pc = PC_W'(r.current_pc) + PC_W'(1);
         if (r.mode == MODE_LOAD) begin
            reg_file[r.reg_index] = r.load_value;
            next_pc = PC_W'(r.current_pc);
         end else begin
            op = op_type'(r.instruction[7:4]);
            rd = r.instruction[3:2];
            rs = r.instruction[1:0];
            a  = reg_file[rd];
            b  = reg_file[rs];
            // Quotient and remainder are formed on magnitudes, so the most negative
            // value divided by minus one wraps instead of overflowing.
            quotient  = (b != 0) ? magnitude(a) / magnitude(b) : '0;
            remainder = (b != 0) ? magnitude(a) % magnitude(b) : '0;
            case (op)
               OP_ADD: reg_file[rd] = a + b;
               OP_SUB: reg_file[rd] = a - b;
               OP_MUL: reg_file[rd] = a * b;
               OP_DIV: begin
                  if (b != 0)
                     reg_file[rd] = (a[DATA_W-1] ^ b[DATA_W-1]) ? 32'd0 - quotient : quotient;
               end
               OP_MOD: begin
                  if (b != 0)
                     reg_file[rd] = a[DATA_W-1] ? 32'd0 - remainder : remainder;
               end
               OP_INC: reg_file[rd] = a + 32'd1;
               OP_DEC: reg_file[rd] = a - 32'd1;
               OP_MOV: reg_file[rd] = b;
               OP_NOT: reg_file[rd] = ~a;
               OP_GT:  reg_file[rd] = ($signed(a) > $signed(b)) ? 32'd1 : 32'd0;
               OP_LT:  reg_file[rd] = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
               OP_EQ:  reg_file[rd] = (a == b) ? 32'd1 : 32'd0;
               OP_JMP: next_pc = PC_W'(a % DATA_W'(PROG_LEN));
               OP_JZ: begin
                  if (a == 0) next_pc = PC_W'(b % DATA_W'(PROG_LEN));
               end
               OP_JNZ: begin
                  if (a != 0) next_pc = PC_W'(b % DATA_W'(PROG_LEN));
               end
               default: ;
            endcase
         end
         state.next_pc = next_pc;
         state.reg_a   = reg_file[0];
         state.reg_b   = reg_file[1];
         state.reg_c   = reg_file[2];
         state.reg_d   = reg_file[3];
         return state;
      endfunction

      function void take_request(req_type r);
         if (r.mode == MODE_LOAD) begin
            loads++;
         end else begin
            instructions++;
            opcodes_seen[r.instruction[7:4]] = 1'b1;
         end
         predicted_states.push_back(step_machine(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type           want;
         logic [DATA_W-1:0] got_regs [REG_COUNT];
         logic [DATA_W-1:0] want_regs [REG_COUNT];
         string             names [REG_COUNT];
         responses++;
         if (predicted_states.size() == 0) begin
            $error("response transaction arrived with no request outstanding");
            errors++;
            return;
         end
         want = predicted_states.pop_front();
         if (got.next_pc !== want.next_pc) begin
            $error("next_pc: expected %0d, got %0d", want.next_pc, got.next_pc);
            errors++;
         end
         names     = '{"reg_a", "reg_b", "reg_c", "reg_d"};
         got_regs  = '{got.reg_a, got.reg_b, got.reg_c, got.reg_d};
         want_regs = '{want.reg_a, want.reg_b, want.reg_c, want.reg_d};
         foreach (got_regs[i]) begin
            if (got_regs[i] !== want_regs[i]) begin
               $error("%s: expected 0x%08h, got 0x%08h", names[i], want_regs[i], got_regs[i]);
               errors++;
            end
         end
      endfunction

      function int pending();
         return predicted_states.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   register_machine_scoreboard scoreboard;
   bit          sender_idles;
   bit          receiver_idles;
   int unsigned idle_cycles = 0;

   tiny_register_machine_step_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic req_type load_request(input logic [1:0] idx,
                                            input logic [DATA_W-1:0] value);
      req_type r;
      r.mode        = MODE_LOAD;
      r.instruction = 8'($urandom);
      r.current_pc  = 2'($urandom);
      r.reg_index   = idx;
      r.load_value  = value;
      return r;
   endfunction

   function automatic req_type exec_request(input op_type op, input logic [1:0] rd,
                                            input logic [1:0] rs, input logic [1:0] pc);
      req_type r;
      r.mode        = ~MODE_LOAD;
      r.instruction = {op, rd, rs};
      r.current_pc  = pc;
      r.reg_index   = 2'($urandom);
      r.load_value  = $urandom;
      return r;
   endfunction

   // Boundary values and small operands show up often so that division, remainder
   // and the compares hit their interesting cases.
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'($urandom_range(0, 15)) - 32'd8;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input req_type item);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      scoreboard.take_request(item);
   endtask

   initial begin
      int unsigned gap;
      int unsigned count;
      count = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (count % 50 == 0) receiver_idles = ($urandom_range(0, 3) != 0);
         gap = receiver_idles ? $urandom_range(0, 19) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         scoreboard.check_response(rsp_data);
         count++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned n;
      scoreboard     = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Register 3 is still zero from reset, which the divide-by-zero cases rely on.
      send_request(load_request(2'd0, 32'h8000_0000));
      send_request(load_request(2'd1, 32'hffff_ffff));
      send_request(load_request(2'd2, 32'h7fff_ffff));
      send_request(exec_request(OP_DIV, 2'd0, 2'd1, 2'd2));
      send_request(exec_request(OP_MOD, 2'd0, 2'd1, 2'd2));
      send_request(exec_request(OP_DIV, 2'd2, 2'd3, 2'd1));
      send_request(exec_request(OP_MOD, 2'd2, 2'd3, 2'd1));
      send_request(load_request(2'd3, 32'd2));
      send_request(load_request(2'd0, 32'hffff_fff9));
      send_request(exec_request(OP_MOD, 2'd0, 2'd3, 2'd0));
      send_request(exec_request(OP_ADD, 2'd2, 2'd2, 2'd1));
      send_request(exec_request(OP_SUB, 2'd0, 2'd2, 2'd2));
      send_request(exec_request(OP_MUL, 2'd2, 2'd2, 2'd0));
      send_request(exec_request(OP_INC, 2'd1, 2'd0, 2'd1));
      send_request(exec_request(OP_JZ, 2'd1, 2'd0, 2'd2));
      send_request(exec_request(OP_DEC, 2'd1, 2'd0, 2'd3));
      send_request(exec_request(OP_MOV, 2'd0, 2'd1, 2'd0));
      send_request(exec_request(OP_NOT, 2'd3, 2'd0, 2'd1));
      send_request(exec_request(OP_GT, 2'd2, 2'd1, 2'd2));
      send_request(exec_request(OP_LT, 2'd3, 2'd2, 2'd0));
      send_request(exec_request(OP_EQ, 2'd0, 2'd1, 2'd1));
      // A negative register as a jump target must still land inside the program.
      send_request(exec_request(OP_JMP, 2'd1, 2'd0, 2'd0));
      send_request(exec_request(OP_JZ, 2'd1, 2'd0, 2'd3));
      send_request(exec_request(OP_JNZ, 2'd1, 2'd1, 2'd1));
      send_request(exec_request(OP_NOP, 2'd0, 2'd0, 2'd3));

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) sender_idles = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0)
            send_request(load_request(2'($urandom), pick_value()));
         else
            send_request(exec_request(op_type'($urandom_range(0, 15)), 2'($urandom),
                                      2'($urandom), 2'($urandom)));
      end
      req_valid <= 1'b0;

      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Covered %0d register loads and %0d executed instructions using %0d of 16 opcodes.",
               scoreboard.loads, scoreboard.instructions, $countones(scoreboard.opcodes_seen));
      $display("Compared %0d response transactions; %0d field mismatches found.",
               scoreboard.responses, scoreboard.errors);
      if (scoreboard.errors == 0 && scoreboard.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
